// ===== rtl/core/kway_heap_merge_defines.svh =====
// assertion macros for the k-way merge block
// used by the top level only, relies on clk_i and rst_ni in scope
`ifndef KWAY_HEAP_MERGE_DEFINES_SVH
`define KWAY_HEAP_MERGE_DEFINES_SVH

// same-cycle implication
`define KWHM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kway_heap_merge assertion failed");

// next-cycle implication
`define KWHM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kway_heap_merge assertion failed");

`endif

// ===== rtl/core/kwhm_pkg.sv =====
// shared types, sizes and key function of the k-way merge block
// no dependencies
`timescale 1ns / 1ps

package kwhm_pkg;

  localparam int unsigned RUNS    = 16;
  localparam int unsigned IDX_W   = $clog2(RUNS);
  localparam int unsigned CNT_W   = $clog2(RUNS + 1);
  localparam int unsigned RUN_W   = 4;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned COORD_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PRIME   = 2'd0,
    FUNC_INS_POP = 2'd1,
    FUNC_POP     = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_READ0,
    S_SCAN,
    S_MOVE,
    S_EMPTY
  } state_e;

  typedef struct packed {
    logic capture;
    logic store;
    logic scan_init;
    logic scan_read;
    logic scan_cmp;
    logic pop;
    logic empty;
  } dp_cmd_t;

  typedef struct packed {
    func_e            func;
    logic             empty;
    logic             more;
    logic             scan_last;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } dp_status_t;

  // float bit pattern to unsigned key in float order, both zeros equal
  function automatic logic [COORD_W-1:0] order_key(input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] v;
    v = b;
    if (v == {1'b1, {(COORD_W-1){1'b0}}}) begin
      v = '0;
    end
    if (v[COORD_W-1]) begin
      return ~v;
    end
    return v | {1'b1, {(COORD_W-1){1'b0}}};
  endfunction

endpackage

// ===== rtl/core/kwhm_ctrl.sv =====
// sequencer of the k-way merge block: store, linear min scan, pop
// depends on kwhm_pkg
`timescale 1ns / 1ps

module kwhm_ctrl
  import kwhm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store     = (status_i.func == FUNC_PRIME) ||
                          (status_i.func == FUNC_INS_POP);
        cmd_o.scan_init = 1'b1;
        case (status_i.func)
          FUNC_INS_POP: state_d = S_READ0;
          FUNC_POP:     state_d = status_i.empty ? S_EMPTY : S_READ0;
          default:      state_d = S_IDLE;
        endcase
      end
      S_READ0: begin
        cmd_o.scan_read = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_cmp  = 1'b1;
        cmd_o.scan_read = status_i.more;
        if (status_i.scan_last) begin
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        if (status_i.out_free) begin
          cmd_o.pop = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.empty = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/kwhm_dp.sv =====
// datapath of the k-way merge block: head store, scan compare, output register
// depends on kwhm_pkg
`timescale 1ns / 1ps

module kwhm_dp
  import kwhm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic               cfg_we_i,
  input  logic               cfg_sort_by_x_i,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [RUN_W-1:0]   run_index_i,
  input  logic [COORD_W-1:0] x_bits_i,
  input  logic [COORD_W-1:0] y_bits_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [COORD_W-1:0] out_x_bits_o,
  output logic [COORD_W-1:0] out_y_bits_o,
  output logic [RUN_W-1:0]   out_run_o,
  output logic               last_o,
  output logic               status_bit_o
);

  logic [COORD_W-1:0] mem_x [RUNS];
  logic [COORD_W-1:0] mem_y [RUNS];
  logic [RUN_W-1:0]   mem_run [RUNS];

  logic               sort_by_x_q;
  func_e              func_q;
  logic [RUN_W-1:0]   run_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   rd_addr_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [COORD_W-1:0] rd_x_q, rd_y_q;
  logic [RUN_W-1:0]   rd_run_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [COORD_W-1:0] best_key_q, best_x_q, best_y_q;
  logic [RUN_W-1:0]   best_run_q;
  logic               out_valid_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;
  logic [RUN_W-1:0]   out_run_q;
  logic               out_last_q, out_status_q;

  logic               not_full;
  logic [CNT_W-1:0]   count_m1;
  logic [COORD_W-1:0] rd_key;
  logic               take;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [COORD_W-1:0] wr_x, wr_y;
  logic [RUN_W-1:0]   wr_run;

  assign not_full = count_q < CNT_W'(RUNS);
  assign count_m1 = count_q - CNT_W'(1);
  assign rd_key   = order_key(sort_by_x_q ? rd_x_q : rd_y_q);
  assign take     = (rd_idx_q == '0) || (rd_key < best_key_q) ||
                    ((rd_key == best_key_q) && (rd_run_q < best_run_q));

  // single write port: store at the tail, or move the tail into the hole
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IDX_W-1:0];
    wr_x    = x_q;
    wr_y    = y_q;
    wr_run  = run_q;
    if (cmd_i.store && not_full) begin
      wr_en = 1'b1;
    end else if (cmd_i.pop && (CNT_W'(best_idx_q) != count_m1)) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_q;
      wr_x    = rd_x_q;
      wr_y    = rd_y_q;
      wr_run  = rd_run_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[wr_addr]   <= wr_x;
      mem_y[wr_addr]   <= wr_y;
      mem_run[wr_addr] <= wr_run;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_read) begin
      rd_x_q   <= mem_x[rd_addr_q[IDX_W-1:0]];
      rd_y_q   <= mem_y[rd_addr_q[IDX_W-1:0]];
      rd_run_q <= mem_run[rd_addr_q[IDX_W-1:0]];
      rd_idx_q <= rd_addr_q[IDX_W-1:0];
    end
  end

  // captured word, running minimum and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(func_i);
      run_q  <= run_index_i;
      x_q    <= x_bits_i;
      y_q    <= y_bits_i;
    end
    if (cmd_i.scan_cmp && take) begin
      best_idx_q <= rd_idx_q;
      best_key_q <= rd_key;
      best_run_q <= rd_run_q;
      best_x_q   <= rd_x_q;
      best_y_q   <= rd_y_q;
    end
    if (cmd_i.pop) begin
      out_x_q      <= best_x_q;
      out_y_q      <= best_y_q;
      out_run_q    <= best_run_q;
      out_last_q   <= (count_m1 == '0);
      out_status_q <= 1'b0;
    end else if (cmd_i.empty) begin
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_run_q    <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.store && not_full) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_by_x_q <= 1'b1;
      count_q     <= '0;
      rd_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sort_by_x_q <= cfg_sort_by_x_i;
      end
      count_q <= count_d;
      if (cmd_i.scan_init) begin
        rd_addr_q <= '0;
      end else if (cmd_i.scan_read) begin
        rd_addr_q <= rd_addr_q + CNT_W'(1);
      end
      if (cmd_i.pop || cmd_i.empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.func      = func_q;
  assign status_o.empty     = (count_q == '0);
  assign status_o.more      = (rd_addr_q < count_q);
  assign status_o.scan_last = (CNT_W'(rd_idx_q) == count_m1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.count     = count_q;

  assign out_valid_o  = out_valid_q;
  assign out_x_bits_o = out_x_q;
  assign out_y_bits_o = out_y_q;
  assign out_run_o    = out_run_q;
  assign last_o       = out_last_q;
  assign status_bit_o = out_status_q;

endmodule

// ===== rtl/core/kway_heap_merge.sv =====
// top level of the k-way merge block: sequencer plus datapath
// depends on kwhm_pkg, kwhm_ctrl, kwhm_dp and kway_heap_merge_defines.svh
//
// input channel (in_valid_i/in_ready_o) takes one word: func_i, run_index_i,
// x_bits_i, y_bits_i. func 0 primes a run head, func 1 inserts the next head
// of the last popped run and pops, func 2 only pops, func 3 is ignored.
// output channel (out_valid_o/out_ready_i) returns one word per pop: point,
// run, last (store empty afterwards) and status (1 when nothing was stored).
// config channel (cfg_valid_i/cfg_ready_o) writes sort_by_x, always ready;
// write it only between words.
// a pop scans the n stored heads one per cycle through the head memory read
// port, then moves the minimum into the output register once that is free;
// the next word is taken only after that. a prime passes capture and store,
// an empty pop capture, store and the empty state.
// reset empties the store and selects x order. a result waits in the output
// register while the receiver stalls; a prime is still taken then, a pop
// waits until the register frees.
`timescale 1ns / 1ps
`include "kway_heap_merge_defines.svh"

module kway_heap_merge
  import kwhm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_sort_by_x_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [RUN_W-1:0]   run_index_i,
  input  logic [COORD_W-1:0] x_bits_i,
  input  logic [COORD_W-1:0] y_bits_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COORD_W-1:0] out_x_bits_o,
  output logic [COORD_W-1:0] out_y_bits_o,
  output logic [RUN_W-1:0]   out_run_o,
  output logic               last_o,
  output logic               status_o
);

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready_o = 1'b1;

  kwhm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  kwhm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (st),
    .cfg_we_i        (cfg_valid_i),
    .cfg_sort_by_x_i (cfg_sort_by_x_i),
    .func_i          (func_i),
    .run_index_i     (run_index_i),
    .x_bits_i        (x_bits_i),
    .y_bits_i        (y_bits_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_x_bits_o    (out_x_bits_o),
    .out_y_bits_o    (out_y_bits_o),
    .out_run_o       (out_run_o),
    .last_o          (last_o),
    .status_bit_o    (status_o)
  );

  `KWHM_ASSERT_NOW(a_count_bound, 1'b1, st.count <= CNT_W'(RUNS))
  `KWHM_ASSERT_NOW(a_empty_word_clear, out_valid_o && status_o, (out_run_o == '0) && !last_o && (out_x_bits_o == '0))
  `KWHM_ASSERT_NEXT(a_one_word_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
  `KWHM_ASSERT_NEXT(a_prime_grows, in_valid_i && in_ready_o && (func_i == FUNC_PRIME) && (st.count < CNT_W'(RUNS)), ##1 (st.count == $past(st.count, 2) + CNT_W'(1)))

endmodule

// ===== test/kway_heap_merge_tb.sv =====
// self-checking bench for kway_heap_merge: directed table then random merge traffic
// scores every popped word against an in-bench linear-scan predictor, depends on kwhm_pkg and kway_heap_merge
`timescale 1ns / 1ps

module kway_heap_merge_tb;
  import kwhm_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 130;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [RUN_W-1:0]   run;
    logic               last;
    logic               status;
  } pop_word_t;

  typedef struct {
    func_e              f;
    logic [RUN_W-1:0]   run;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    bit                 typed;
    pop_word_t          want;
  } plan_row_t;

  typedef enum int {RX_BURSTY, RX_HOLD, RX_OPEN} rx_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_sort_by_x_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [FUNC_W-1:0]  func_i;
  logic [RUN_W-1:0]   run_index_i;
  logic [COORD_W-1:0] x_bits_i;
  logic [COORD_W-1:0] y_bits_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [COORD_W-1:0] out_x_bits_o;
  logic [COORD_W-1:0] out_y_bits_o;
  logic [RUN_W-1:0]   out_run_o;
  logic               last_o;
  logic               status_o;

  // predictor state
  logic [COORD_W-1:0] head_x [RUNS];
  logic [COORD_W-1:0] head_y [RUNS];
  logic [RUN_W-1:0]   head_run [RUNS];
  int                 head_cnt;
  bit                 order_by_x;

  pop_word_t expected_pops [$];
  plan_row_t dir_plan [$];
  int        runs_left [RUNS];
  int        words_sent;
  int        mismatches;
  int        stall_cycles;
  bit        tx_quiet;
  rx_mode_e  rx_mode;

  kway_heap_merge dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_sort_by_x_i (cfg_sort_by_x_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .run_index_i     (run_index_i),
    .x_bits_i        (x_bits_i),
    .y_bits_i        (y_bits_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_x_bits_o    (out_x_bits_o),
    .out_y_bits_o    (out_y_bits_o),
    .out_run_o       (out_run_o),
    .last_o          (last_o),
    .status_o        (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // float pattern to unsigned rank, both zeros equal
  function automatic logic [31:0] float_rank(input logic [31:0] b);
    if (b[30:0] == 31'd0) begin
      return 32'h8000_0000;
    end
    return b[31] ? ~b : {1'b1, b[30:0]};
  endfunction

  function automatic bit merge_predict(input func_e f, input logic [RUN_W-1:0] r,
                                       input logic [31:0] x, input logic [31:0] y,
                                       output pop_word_t w);
    int          best;
    int          i;
    logic [31:0] best_key;
    logic [31:0] cur_key;
    w = '0;
    if (f == FUNC_NOP) begin
      return 1'b0;
    end
    if (f != FUNC_POP && head_cnt < RUNS) begin
      head_x[head_cnt]   = x;
      head_y[head_cnt]   = y;
      head_run[head_cnt] = r;
      head_cnt++;
    end
    if (f == FUNC_PRIME) begin
      return 1'b0;
    end
    if (head_cnt == 0) begin
      w.status = 1'b1;
      return 1'b1;
    end
    best = 0;
    best_key = float_rank(order_by_x ? head_x[0] : head_y[0]);
    for (i = 1; i < head_cnt; i++) begin
      cur_key = float_rank(order_by_x ? head_x[i] : head_y[i]);
      if (cur_key < best_key || (cur_key == best_key && head_run[i] < head_run[best])) begin
        best_key = cur_key;
        best = i;
      end
    end
    w.x = head_x[best];
    w.y = head_y[best];
    w.run = head_run[best];
    head_cnt--;
    // last slot fills the hole
    head_x[best]   = head_x[head_cnt];
    head_y[best]   = head_y[head_cnt];
    head_run[best] = head_run[head_cnt];
    w.last = (head_cnt == 0);
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom;
      4: begin
        case ($urandom_range(0, 9))
          0: return 32'h0000_0000;
          1: return 32'h8000_0000;
          2: return 32'h7F80_0000;
          3: return 32'hFF80_0000;
          4: return 32'h7FC0_0000;
          5: return 32'hFFC0_0000;
          6: return 32'h0000_0001;
          7: return 32'h8000_0001;
          8: return 32'h7F7F_FFFF;
          default: return 32'hFF7F_FFFF;
        endcase
      end
      5: begin
        case ($urandom_range(0, 3))
          0: return 32'h3F80_0000;
          1: return 32'hBF80_0000;
          2: return 32'h4000_0000;
          default: return 32'h0000_0000;
        endcase
      end
      6: return {1'b0, 8'($urandom_range(0, 254)), 23'($urandom)};
      default: return {1'b1, 8'($urandom_range(0, 254)), 23'($urandom)};
    endcase
  endfunction

  // next point of a sorted run: rank not below prev
  function automatic logic [31:0] later_coord(input logic [31:0] prev);
    logic [31:0] rank;
    logic [31:0] step;
    logic [32:0] room;
    logic [32:0] sum;
    logic [31:0] pat;
    rank = float_rank(prev);
    room = {1'b0, ~rank} + 33'd1;
    case ($urandom_range(0, 3))
      0: step = '0;
      1: step = 32'($urandom_range(1, 64));
      2: step = $urandom & 32'h000F_FFFF;
      default: step = 32'({1'b0, $urandom} % room);
    endcase
    sum = {1'b0, rank} + {1'b0, step};
    if (sum[32]) begin
      sum[31:0] = 32'hFFFF_FFFF;
    end
    pat = sum[31] ? {1'b0, sum[30:0]} : ~sum[31:0];
    if (pat == 32'h0 && $urandom_range(0, 1) == 1) begin
      pat = 32'h8000_0000;
    end
    return pat;
  endfunction

  task automatic send_word(input func_e f, input logic [RUN_W-1:0] r,
                           input logic [31:0] x, input logic [31:0] y,
                           output bit has, output pop_word_t w);
    in_valid_i  <= 1'b1;
    func_i      <= f;
    run_index_i <= r;
    x_bits_i    <= x;
    y_bits_i    <= y;
    do @(posedge clk_i); while (!in_ready_o);
    has = merge_predict(f, r, x, y, w);
    if (has) begin
      expected_pops = {expected_pops, w};
    end
    if (f != FUNC_NOP) begin
      words_sent++;
    end
    if (!tx_quiet && rx_mode != RX_HOLD && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_pops.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_order(input bit by_x);
    cfg_valid_i     <= 1'b1;
    cfg_sort_by_x_i <= by_x;
    do @(posedge clk_i); while (!cfg_ready_o);
    order_by_x = by_x;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(input func_e f, input logic [RUN_W-1:0] r, input logic [31:0] x,
                         input logic [31:0] y, input bit typed, input pop_word_t want);
    plan_row_t row;
    row.f = f;
    row.run = r;
    row.x = x;
    row.y = y;
    row.typed = typed;
    row.want = want;
    dir_plan = {dir_plan, row};
  endtask

  // prime a set of runs, then pop and refill until every run is used up
  task automatic run_merge();
    int          r;
    bit          has;
    pop_word_t   w;
    logic [31:0] nx;
    logic [31:0] ny;
    repeat ($urandom_range(1, RUNS)) begin
      r = $urandom_range(0, RUNS - 1);
      runs_left[r] = $urandom_range(0, 6);
      send_word(FUNC_PRIME, 4'(r), pick_coord(), pick_coord(), has, w);
    end
    send_word(FUNC_POP, 4'($urandom_range(0, 15)), $urandom, $urandom, has, w);
    while (w.status == 1'b0 && !(w.last && runs_left[w.run] == 0)) begin
      if (runs_left[w.run] != 0) begin
        runs_left[w.run]--;
        nx = order_by_x ? later_coord(w.x) : pick_coord();
        ny = order_by_x ? pick_coord() : later_coord(w.y);
        send_word(FUNC_INS_POP, w.run, nx, ny, has, w);
      end else begin
        send_word(FUNC_POP, 4'($urandom_range(0, 15)), $urandom, $urandom, has, w);
      end
    end
  endtask

  task automatic run_noise();
    bit        has;
    pop_word_t w;
    int        f;
    if ($urandom_range(0, 3) == 0) begin
      // overfill the store, then insert into it while full
      repeat ($urandom_range(17, 20)) begin
        send_word(FUNC_PRIME, 4'($urandom_range(0, 15)), pick_coord(), pick_coord(), has, w);
      end
      send_word(FUNC_INS_POP, 4'($urandom_range(0, 15)), pick_coord(), pick_coord(), has, w);
    end
    repeat ($urandom_range(3, 12)) begin
      f = $urandom_range(0, 3);
      send_word(func_e'(f), 4'($urandom_range(0, 15)), pick_coord(), pick_coord(), has, w);
    end
  endtask

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_pops
    pop_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pops.size() == 0) begin
        $display("%0t: word with none expected, expected none got x %h y %h run %h last %b status %b",
                 $time, out_x_bits_o, out_y_bits_o, out_run_o, last_o, status_o);
        mismatches++;
      end else begin
        want = expected_pops.pop_front();
        check_field("out_x_bits", want.x, out_x_bits_o);
        check_field("out_y_bits", want.y, out_y_bits_o);
        check_field("out_run", 32'(want.run), 32'(out_run_o));
        check_field("last", 32'(want.last), 32'(last_o));
        check_field("status", 32'(want.status), 32'(status_o));
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  initial begin : receiver
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_mode == RX_HOLD) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_mode = RX_BURSTY;
      end else if (rx_mode == RX_OPEN || $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    bit        has;
    pop_word_t w;
    int        target;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_sort_by_x_i = 1'b1;
    in_valid_i      = 1'b0;
    func_i          = FUNC_NOP;
    run_index_i     = '0;
    x_bits_i        = '0;
    y_bits_i        = '0;
    head_cnt        = 0;
    order_by_x      = 1'b1;
    words_sent      = 0;
    mismatches      = 0;
    stall_cycles    = 0;
    tx_quiet        = 1'b0;
    rx_mode         = RX_BURSTY;
    foreach (runs_left[i]) runs_left[i] = 0;
    foreach (head_x[i]) begin
      head_x[i] = '0;
      head_y[i] = '0;
      head_run[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_order(1'b1);

    // empty pops, single-entry extremes, zero signs, infinities, nan, ties
    add_row(FUNC_POP,     4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1,
            {32'h0, 32'h0, 4'd0, 1'b0, 1'b1});
    add_row(FUNC_INS_POP, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
            {32'hFFFF_FFFF, 32'h0, 4'd15, 1'b1, 1'b0});
    add_row(FUNC_INS_POP, 4'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
            {32'h0, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b0});
    add_row(FUNC_NOP,     4'd7,  32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0);
    add_row(FUNC_POP,     4'd9,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            {32'h0, 32'h0, 4'd0, 1'b0, 1'b1});
    add_row(FUNC_PRIME,   4'd3,  32'h0000_0000, 32'h3F80_0000, 1'b0, '0);
    add_row(FUNC_PRIME,   4'd1,  32'h8000_0000, 32'hBF80_0000, 1'b0, '0);
    add_row(FUNC_PRIME,   4'd9,  32'h7F80_0000, 32'h0000_0000, 1'b0, '0);
    add_row(FUNC_PRIME,   4'd2,  32'hFF80_0000, 32'h7F7F_FFFF, 1'b0, '0);
    add_row(FUNC_PRIME,   4'd4,  32'h0000_0001, 32'h8000_0001, 1'b0, '0);
    add_row(FUNC_PRIME,   4'd4,  32'h0000_0001, 32'h0000_0002, 1'b0, '0);
    add_row(FUNC_PRIME,   4'd6,  32'h7FC0_0000, 32'h0000_0000, 1'b0, '0);
    add_row(FUNC_PRIME,   4'd8,  32'hFFC0_0000, 32'h0000_0000, 1'b0, '0);
    add_row(FUNC_PRIME,   4'd5,  32'h8000_0001, 32'hFF80_0000, 1'b0, '0);
    add_row(FUNC_POP,     4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, '0);
    add_row(FUNC_INS_POP, 4'd8,  32'hFF7F_FFFF, 32'h7F80_0000, 1'b0, '0);
    repeat (9) add_row(FUNC_POP, 4'd10, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0);
    add_row(FUNC_POP,     4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1,
            {32'h0, 32'h0, 4'd0, 1'b0, 1'b1});

    foreach (dir_plan[i]) begin
      send_word(dir_plan[i].f, dir_plan[i].run, dir_plan[i].x, dir_plan[i].y, has, w);
      if (dir_plan[i].typed) begin
        expected_pops[expected_pops.size() - 1] = dir_plan[i].want;
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      set_order(ph % 2 == 1);
      if (ph == 3) begin
        rx_mode = RX_HOLD;
      end
      if (ph == PHASES - 1) begin
        tx_quiet = 1'b1;
        rx_mode = RX_OPEN;
      end
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        if ($urandom_range(0, 9) < 8) begin
          run_merge();
        end else begin
          run_noise();
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
